FILE: rtl/core/ptt_pkg.sv
package ptt_pkg;

  localparam int SLOTS       = 32;
  localparam int MAX_RESULTS = 32;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int FC_W  = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NONE      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [7:0]  tsk_id;
    logic [30:0] period;
    logic [31:0] last_fire;
    logic        one_shot;
  } slot_t;

  typedef struct packed {
    logic             we;
    logic             keep;
    logic [IDX_W-1:0] addr;
    slot_t            data;
  } slot_wr_t;

endpackage

FILE: rtl/core/periodic_task_timer_table.sv
// Timer slot table. Start an add, remove or tick with start while busy is
// low. An add, remove or tick scans the slots one per cycle from the slot
// memory, whose read data is registered; an add stops at the first empty
// slot and a remove at the first slot with its task id, while a tick always
// reads every slot. Kind 3 gives a single result and scans no slot.
// Results appear on out_* for one cycle each with out_strobe, and the
// receiver cannot stall them. A tick gives one result per fired slot in slot
// order, the final one with out_last set, or a single nothing-fired result.
module periodic_task_timer_table
  import ptt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_task_id,
  input  logic [30:0] in_period_ms,
  input  logic        in_one_shot,
  input  logic [31:0] in_now_ms,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [7:0]  out_fired_task,
  output logic        out_fired,
  output logic        out_last
);

  state_t           state_r, state_nxt;
  kind_t            kind_r, kind_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [30:0]      period_r, period_nxt;
  logic             shot_r, shot_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic             rdv_r, rdv_nxt;
  logic [IDX_W-1:0] eval_idx_r, eval_idx_nxt;
  logic [FC_W-1:0]  fire_cnt_r, fire_cnt_nxt;
  logic             hold_vld_r, hold_vld_nxt;
  logic [7:0]       hold_task_r, hold_task_nxt;
  logic             strobe_r, strobe_nxt;
  status_t          status_r, status_nxt;
  logic [7:0]       ftask_r, ftask_nxt;
  logic             fired_r, fired_nxt;
  logic             last_r, last_nxt;

  logic [IDX_W-1:0] raddr;
  slot_t            rdata;
  slot_wr_t         wr;
  logic [31:0]      elapsed;
  logic             due;
  logic             accept;
  logic             last_idx;

  ptt_slot_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .raddr (raddr),
    .rdata (rdata),
    .wr    (wr)
  );

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign raddr    = issue_r[IDX_W-1:0];
  assign elapsed  = now_r - rdata.last_fire;
  assign due      = (rdata.tsk_id != 8'd0) && (elapsed > {1'b0, rdata.period}) &&
                    (fire_cnt_r < FC_W'(MAX_RESULTS));
  assign last_idx = (eval_idx_r == IDX_W'(SLOTS - 1));

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    id_nxt        = id_r;
    period_nxt    = period_r;
    shot_nxt      = shot_r;
    now_nxt       = now_r;
    issue_nxt     = issue_r;
    rdv_nxt       = 1'b0;
    eval_idx_nxt  = eval_idx_r;
    fire_cnt_nxt  = fire_cnt_r;
    hold_vld_nxt  = hold_vld_r;
    hold_task_nxt = hold_task_r;
    strobe_nxt    = 1'b0;
    status_nxt    = ST_OK;
    ftask_nxt     = 8'd0;
    fired_nxt     = 1'b0;
    last_nxt      = 1'b0;
    wr            = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt     = kind_t'(in_kind);
          id_nxt       = in_task_id;
          period_nxt   = in_period_ms;
          shot_nxt     = in_one_shot;
          now_nxt      = in_now_ms;
          issue_nxt    = '0;
          fire_cnt_nxt = '0;
          hold_vld_nxt = 1'b0;
          if (kind_t'(in_kind) == KIND_NOP) begin
            strobe_nxt = 1'b1;
            last_nxt   = 1'b1;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Reads run one slot ahead of the evaluation of the returned entry.
        if (issue_r < CNT_W'(SLOTS)) begin
          rdv_nxt      = 1'b1;
          eval_idx_nxt = issue_r[IDX_W-1:0];
          issue_nxt    = issue_r + CNT_W'(1);
        end
        if (rdv_r) begin
          wr.addr = eval_idx_r;
          case (kind_r)
            KIND_ADD: begin
              if (rdata.tsk_id == 8'd0) begin
                wr.we   = (id_r != 8'd0);
                wr.keep = 1'b1;
                wr.data = '{tsk_id: id_r, period: period_r, last_fire: now_r,
                            one_shot: shot_r};
                strobe_nxt = 1'b1;
                last_nxt   = 1'b1;
                rdv_nxt    = 1'b0;
                state_nxt  = S_IDLE;
              end else if (last_idx) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_FULL;
                last_nxt   = 1'b1;
                state_nxt  = S_IDLE;
              end
            end
            KIND_REMOVE: begin
              if (rdata.tsk_id == id_r) begin
                wr.we      = 1'b1;
                wr.keep    = 1'b0;
                strobe_nxt = 1'b1;
                last_nxt   = 1'b1;
                rdv_nxt    = 1'b0;
                state_nxt  = S_IDLE;
              end else if (last_idx) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_NOT_FOUND;
                last_nxt   = 1'b1;
                state_nxt  = S_IDLE;
              end
            end
            default: begin
              if (due) begin
                wr.we   = 1'b1;
                wr.keep = !rdata.one_shot;
                wr.data = '{tsk_id: rdata.tsk_id, period: rdata.period,
                            last_fire: now_r, one_shot: rdata.one_shot};
                // The previous firing goes out now that it is known not to be final.
                if (hold_vld_r) begin
                  strobe_nxt = 1'b1;
                  ftask_nxt  = hold_task_r;
                  fired_nxt  = 1'b1;
                end
                hold_vld_nxt  = 1'b1;
                hold_task_nxt = rdata.tsk_id;
                fire_cnt_nxt  = fire_cnt_r + FC_W'(1);
              end
              if (last_idx) begin
                state_nxt = S_DONE;
              end
            end
          endcase
        end
      end

      S_DONE: begin
        strobe_nxt = 1'b1;
        last_nxt   = 1'b1;
        if (hold_vld_r) begin
          ftask_nxt = hold_task_r;
          fired_nxt = 1'b1;
        end else begin
          status_nxt = ST_NONE;
        end
        hold_vld_nxt = 1'b0;
        state_nxt    = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rdv_r      <= 1'b0;
      hold_vld_r <= 1'b0;
      strobe_r   <= 1'b0;
      issue_r    <= '0;
      fire_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      rdv_r      <= rdv_nxt;
      hold_vld_r <= hold_vld_nxt;
      strobe_r   <= strobe_nxt;
      issue_r    <= issue_nxt;
      fire_cnt_r <= fire_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    id_r        <= id_nxt;
    period_r    <= period_nxt;
    shot_r      <= shot_nxt;
    now_r       <= now_nxt;
    eval_idx_r  <= eval_idx_nxt;
    hold_task_r <= hold_task_nxt;
    status_r    <= status_nxt;
    ftask_r     <= ftask_nxt;
    fired_r     <= fired_nxt;
    last_r      <= last_nxt;
  end

  assign out_strobe     = strobe_r;
  assign out_status     = status_r;
  assign out_fired_task = ftask_r;
  assign out_fired      = fired_r;
  assign out_last       = last_r;

endmodule

FILE: rtl/core/ptt_slot_mem.sv
module ptt_slot_mem
  import ptt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] raddr,
  output slot_t            rdata,
  input  slot_wr_t         wr
);

  slot_t            mem [SLOTS];
  logic [SLOTS-1:0] valid_r;
  slot_t            rdata_r;
  logic             rvalid_r;

  // An entry that was never written, or was freed, reads as an empty slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.we) begin
      valid_r[wr.addr] <= wr.keep;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r  <= mem[raddr];
    rvalid_r <= valid_r[raddr];
  end

  assign rdata = rvalid_r ? rdata_r : '0;

endmodule
